@@ rtl/elsp_pkg.sv @@
package elsp_pkg;

  // Ring size
  localparam int SEGMENTS_DEF = 10;
  localparam int SEG_MAX      = 16;
  localparam int SEG_W        = 4;

  // Field widths
  localparam int TIME_W  = 32;
  localparam int ACT_W   = 3;
  localparam int LEVEL_W = 8;
  localparam int PROG_W  = 7;
  localparam int SPEED_W = 8;
  localparam int RUN_W   = 4;
  localparam int IVL_W   = 16;

  localparam logic [LEVEL_W-1:0] LEVEL_FULL = 8'd255;
  localparam logic [LEVEL_W-1:0] LEVEL_OFF  = 8'd0;

  // Configuration port
  localparam int ADDR_W    = 4;
  localparam int DATA_W    = 32;
  localparam int REG_IDX_W = 2;
  localparam logic [RUN_W-1:0] RUN_LEN_RST  = 4'd4;
  localparam logic [IVL_W-1:0] INTERVAL_RST = 16'd200;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_MIRRORED = 2'd0,
    REG_RUN_LEN  = 2'd1,
    REG_INTERVAL = 2'd2
  } reg_idx_t;

  typedef enum logic [ACT_W-1:0] {
    ACT_OFF     = 3'd0,
    ACT_BRIGHT  = 3'd1,
    ACT_SPIN    = 3'd2,
    ACT_PROG    = 3'd3,
    ACT_BREATHE = 3'd4
  } action_t;

  // Breathing ramp: half period = speed * 50 ms, ramp = e * 255 / half
  localparam int HALF_W        = 14;
  localparam int PULSE_STEP_MS = 50;
  localparam int QUOT_W        = 8;
  localparam int DIV_NUM_W     = HALF_W + QUOT_W;

  // Progress: p / 10 as (p * 205) >> 11, exact for p <= 100
  localparam logic [PROG_W-1:0] PROG_MAX = 7'd100;
  localparam int PROG_RECIP = 205;
  localparam int PROG_MUL_W = 15;
  localparam int FULL_W     = 4;

  typedef enum logic [1:0] {
    CMD_UNIFORM  = 2'd0,
    CMD_PATTERN  = 2'd1,
    CMD_PROGRESS = 2'd2
  } cmd_kind_t;

  // One classified tick, handed from the front to the back
  typedef struct packed {
    cmd_kind_t            kind;
    logic [LEVEL_W-1:0]   level;
    logic [FULL_W-1:0]    full;
    logic                 all_on;
    logic [SEG_MAX-1:0]   pattern;
  } cmd_t;

  typedef struct packed {
    logic               mirrored;
    logic [RUN_W-1:0]   run_len;
    logic [IVL_W-1:0]   interval;
    logic               home;
    logic               home_mirrored;
  } cfg_t;

  typedef enum logic [1:0] {
    F_IDLE = 2'd0,
    F_EVAL = 2'd1,
    F_DIV  = 2'd2,
    F_PUSH = 2'd3
  } front_state_t;

  localparam int QDEPTH = 2;

  // Fractional bar segment: rem * 255 / 10, rounded down
  function automatic logic [LEVEL_W-1:0] frac_level(input logic [FULL_W-1:0] rem);
    logic [LEVEL_W-1:0] v;
    case (rem)
      4'd1:    v = 8'd25;
      4'd2:    v = 8'd51;
      4'd3:    v = 8'd76;
      4'd4:    v = 8'd102;
      4'd5:    v = 8'd127;
      4'd6:    v = 8'd153;
      4'd7:    v = 8'd178;
      4'd8:    v = 8'd204;
      4'd9:    v = 8'd229;
      default: v = 8'd0;
    endcase
    return v;
  endfunction

endpackage

@@ rtl/ear_led_segment_pattern_generator.sv @@
// Channel   Dir  Handshake         Payload
// in        in   in_valid/in_stall time_ms, action, brightness, progress, pulse_speed
// out       out  out_valid/out_stall segment, level, last (SEGMENTS items per tick)
// cfg       in   psel/penable/pwrite mirrored @0x0, spinner_run_length @0x4,
//                                    spinner_interval_ms @0x8
//
// Flow: the front steps each tick through accept, evaluate and push, and takes no new tick
// until the push; a breathing tick still on its ramp also waits on the ramp divider, one
// quotient bit per cycle. The back emits one segment per cycle while out_stall is low,
// SEGMENTS per tick; the slower side sets the sustained tick rate.
// Reset: synchronous, active low; clears control and pattern state, no sweep.
// Stalls: a 2-entry command queue separates front and back, so the front keeps
// taking ticks while the output is stalled until the queue fills.
module ear_led_segment_pattern_generator #(
  parameter int SEGMENTS = elsp_pkg::SEGMENTS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // tick input
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [elsp_pkg::TIME_W-1:0]   in_time_ms,
  input  logic [elsp_pkg::ACT_W-1:0]    in_action,
  input  logic [elsp_pkg::LEVEL_W-1:0]  in_brightness,
  input  logic [elsp_pkg::PROG_W-1:0]   in_progress,
  input  logic [elsp_pkg::SPEED_W-1:0]  in_pulse_speed,
  // segment output
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [elsp_pkg::SEG_W-1:0]    out_segment,
  output logic [elsp_pkg::LEVEL_W-1:0]  out_level,
  output logic                          out_last,
  // register port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [elsp_pkg::ADDR_W-1:0]   paddr,
  input  logic [elsp_pkg::DATA_W-1:0]   pwdata,
  output logic [elsp_pkg::DATA_W-1:0]   prdata,
  output logic                          pready
);

  localparam int DW = elsp_pkg::DATA_W;

  logic                           mirrored_r;
  logic [elsp_pkg::RUN_W-1:0]     run_len_r;
  logic [elsp_pkg::IVL_W-1:0]     interval_r;
  logic                           cfg_wr;
  logic [elsp_pkg::REG_IDX_W-1:0] cfg_idx;
  elsp_pkg::cfg_t                 cfg;

  elsp_pkg::cmd_t q_din, q_dout;
  logic           q_push, q_pop, q_full, q_empty;

  // Register file: word index from the byte address, low bits ignored
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = paddr[elsp_pkg::ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mirrored_r <= 1'b0;
      run_len_r  <= elsp_pkg::RUN_LEN_RST;
      interval_r <= elsp_pkg::INTERVAL_RST;
    end else if (cfg_wr) begin
      case (elsp_pkg::reg_idx_t'(cfg_idx))
        elsp_pkg::REG_MIRRORED: mirrored_r <= pwdata[0];
        elsp_pkg::REG_RUN_LEN:  run_len_r  <= pwdata[elsp_pkg::RUN_W-1:0];
        elsp_pkg::REG_INTERVAL: interval_r <= pwdata[elsp_pkg::IVL_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (elsp_pkg::reg_idx_t'(cfg_idx))
      elsp_pkg::REG_MIRRORED: prdata = DW'(mirrored_r);
      elsp_pkg::REG_RUN_LEN:  prdata = DW'(run_len_r);
      elsp_pkg::REG_INTERVAL: prdata = DW'(interval_r);
      default:                prdata = '0;
    endcase
  end

  // Writing the mirror bit also sends the spinner head home
  always_comb begin
    cfg.mirrored      = mirrored_r;
    cfg.run_len       = run_len_r;
    cfg.interval      = interval_r;
    cfg.home          = cfg_wr && (elsp_pkg::reg_idx_t'(cfg_idx) == elsp_pkg::REG_MIRRORED);
    cfg.home_mirrored = pwdata[0];
  end

  // Front: accept, classify, advance spinner and breathing state
  elsp_front #(
    .SEGMENTS (SEGMENTS)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_time_ms     (in_time_ms),
    .in_action      (in_action),
    .in_brightness  (in_brightness),
    .in_progress    (in_progress),
    .in_pulse_speed (in_pulse_speed),
    .q_push         (q_push),
    .q_din          (q_din),
    .q_full         (q_full)
  );

  // Command queue between the two halves
  elsp_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .din   (q_din),
    .pop   (q_pop),
    .dout  (q_dout),
    .full  (q_full),
    .empty (q_empty)
  );

  // Back: expand one command into per-segment levels
  elsp_back #(
    .SEGMENTS (SEGMENTS)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .mirrored    (mirrored_r),
    .q_dout      (q_dout),
    .q_empty     (q_empty),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_segment (out_segment),
    .out_level   (out_level),
    .out_last    (out_last)
  );

endmodule

@@ rtl/elsp_div.sv @@
module elsp_div (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  input  logic [elsp_pkg::DIV_NUM_W-1:0]     num,
  input  logic [elsp_pkg::HALF_W-1:0]        den,
  output logic                               done,
  output logic [elsp_pkg::QUOT_W-1:0]        quot
);

  localparam int HW    = elsp_pkg::HALF_W;
  localparam int QW    = elsp_pkg::QUOT_W;
  localparam int CNT_W = $clog2(QW);

  logic          busy_r;
  logic          done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [HW-1:0] rem_r;
  logic [HW-1:0] den_r;
  logic [QW-1:0] lo_r;
  logic [QW-1:0] quot_r;
  logic [HW:0]   trial;
  logic          ge;

  // Quotient is known to fit QW bits, so the top bits seed the remainder
  assign trial = {rem_r, lo_r[QW-1]};
  assign ge    = trial >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(QW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= num[elsp_pkg::DIV_NUM_W-1 -: HW];
      lo_r  <= num[QW-1:0];
      den_r <= den;
    end else if (busy_r) begin
      rem_r  <= ge ? HW'(trial - {1'b0, den_r}) : trial[HW-1:0];
      lo_r   <= {lo_r[QW-2:0], 1'b0};
      quot_r <= {quot_r[QW-2:0], ge};
    end
  end

  assign done = done_r;
  assign quot = quot_r;

endmodule

@@ rtl/elsp_queue.sv @@
module elsp_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  elsp_pkg::cmd_t din,
  input  logic           pop,
  output elsp_pkg::cmd_t dout,
  output logic           full,
  output logic           empty
);

  localparam int DEPTH = elsp_pkg::QDEPTH;
  localparam int PTR_W = $clog2(DEPTH);

  elsp_pkg::cmd_t    mem_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r;
  logic [PTR_W-1:0]  rd_ptr_r;
  logic [PTR_W:0]    count_r;

  assign full  = count_r == (PTR_W+1)'(DEPTH);
  assign empty = count_r == '0;
  assign dout  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + PTR_W'(1);
      if (pop)  rd_ptr_r <= rd_ptr_r + PTR_W'(1);
      if (push && !pop)      count_r <= count_r + (PTR_W+1)'(1);
      else if (pop && !push) count_r <= count_r - (PTR_W+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= din;
  end

endmodule

@@ rtl/elsp_front.sv @@
module elsp_front #(
  parameter int SEGMENTS = elsp_pkg::SEGMENTS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  elsp_pkg::cfg_t                cfg,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [elsp_pkg::TIME_W-1:0]   in_time_ms,
  input  logic [elsp_pkg::ACT_W-1:0]    in_action,
  input  logic [elsp_pkg::LEVEL_W-1:0]  in_brightness,
  input  logic [elsp_pkg::PROG_W-1:0]   in_progress,
  input  logic [elsp_pkg::SPEED_W-1:0]  in_pulse_speed,
  output logic                          q_push,
  output elsp_pkg::cmd_t                q_din,
  input  logic                          q_full
);

  localparam int SW     = elsp_pkg::SEG_W;
  localparam int DIST_W = SW + 1;
  localparam int TW     = elsp_pkg::TIME_W;
  localparam int HW     = elsp_pkg::HALF_W;
  localparam int QW     = elsp_pkg::QUOT_W;
  localparam int PW     = elsp_pkg::PROG_W;
  localparam int FW     = elsp_pkg::FULL_W;
  localparam int MW     = elsp_pkg::PROG_MUL_W;
  localparam int NW     = elsp_pkg::DIV_NUM_W;

  elsp_pkg::front_state_t fstate_r, fstate_nxt;

  // Latched tick
  logic [TW-1:0]                 time_r;
  logic [elsp_pkg::ACT_W-1:0]    action_r;
  logic [elsp_pkg::LEVEL_W-1:0]  bright_r;
  logic [PW-1:0]                 prog_r;
  logic [elsp_pkg::SPEED_W-1:0]  speed_r;

  // Pattern state
  logic [SW-1:0]                 spin_pos_r;
  logic [TW-1:0]                 spin_last_r;
  logic [SEGMENTS-1:0]           spin_pat_r;
  logic [TW-1:0]                 pulse_start_r;
  logic                          pulse_rising_r;
  logic [elsp_pkg::SPEED_W-1:0]  pulse_speed_r;

  elsp_pkg::cmd_t cmd_r, cmd_eval;

  // Spinner
  logic                spin_step;
  logic [DIST_W-1:0]   spin_dist [SEGMENTS];
  logic [SEGMENTS-1:0] spin_new_pat;
  logic [SW-1:0]       spin_pos_adv;

  // Progress
  logic [PW-1:0]       prog_sat;
  logic [MW-1:0]       prog_mul;
  logic [FW-1:0]       prog_full;
  logic [PW-1:0]       prog_x10;
  logic [PW-1:0]       prog_rem;

  // Breathing
  logic                speed_chg;
  logic [TW-1:0]       start_eff;
  logic                rising_eff;
  logic [TW-1:0]       elapsed;
  logic [HW-1:0]       half;
  logic                e_full;
  logic [NW-1:0]       div_num;
  logic                breathe;

  logic                div_start;
  logic                div_done;
  logic [QW-1:0]       div_quot;

  elsp_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (half),
    .done  (div_done),
    .quot  (div_quot)
  );

  // Spinner: a segment is lit when its distance from the head, walking
  // the spin direction, is below the run length.
  assign spin_step = (time_r - spin_last_r) > TW'(cfg.interval);

  always_comb begin
    for (int j = 0; j < SEGMENTS; j++) begin
      if (cfg.mirrored) begin
        spin_dist[j] = (spin_pos_r >= SW'(j)) ? {1'b0, spin_pos_r} - DIST_W'(j)
                                              : {1'b0, spin_pos_r} + DIST_W'(SEGMENTS - j);
      end else begin
        spin_dist[j] = (SW'(j) >= spin_pos_r) ? DIST_W'(j) - {1'b0, spin_pos_r}
                                              : DIST_W'(j + SEGMENTS) - {1'b0, spin_pos_r};
      end
      spin_new_pat[j] = spin_dist[j] < {1'b0, cfg.run_len};
    end
  end

  always_comb begin
    if (cfg.mirrored) begin
      spin_pos_adv = (spin_pos_r == '0) ? SW'(SEGMENTS - 1) : spin_pos_r - SW'(1);
    end else begin
      spin_pos_adv = (spin_pos_r == SW'(SEGMENTS - 1)) ? '0 : spin_pos_r + SW'(1);
    end
  end

  // Progress: saturate, split into full segments and a remainder
  assign prog_sat  = (prog_r > elsp_pkg::PROG_MAX) ? elsp_pkg::PROG_MAX : prog_r;
  assign prog_mul  = MW'(prog_sat) * MW'(elsp_pkg::PROG_RECIP);
  assign prog_full = prog_mul[MW-1 -: FW];
  assign prog_x10  = PW'({prog_full, 3'b000}) + PW'({prog_full, 1'b0});
  assign prog_rem  = prog_sat - prog_x10;

  // Breathing: restart on speed change, ramp over the half period
  assign breathe    = elsp_pkg::action_t'(action_r) == elsp_pkg::ACT_BREATHE;
  assign speed_chg  = speed_r != pulse_speed_r;
  assign start_eff  = speed_chg ? time_r : pulse_start_r;
  assign rising_eff = speed_chg | pulse_rising_r;
  assign elapsed    = time_r - start_eff;
  assign half       = HW'(speed_r) * HW'(elsp_pkg::PULSE_STEP_MS);
  assign e_full     = elapsed >= TW'(half);
  assign div_num    = {elapsed[HW-1:0], QW'(0)} - NW'(elapsed[HW-1:0]);

  always_comb begin
    cmd_eval         = '0;
    cmd_eval.kind    = elsp_pkg::CMD_UNIFORM;
    cmd_eval.level   = elsp_pkg::LEVEL_OFF;
    case (elsp_pkg::action_t'(action_r))
      elsp_pkg::ACT_BRIGHT: begin
        cmd_eval.level = bright_r;
      end
      elsp_pkg::ACT_SPIN: begin
        cmd_eval.kind    = elsp_pkg::CMD_PATTERN;
        cmd_eval.pattern = elsp_pkg::SEG_MAX'(spin_step ? spin_new_pat : spin_pat_r);
      end
      elsp_pkg::ACT_PROG: begin
        cmd_eval.kind   = elsp_pkg::CMD_PROGRESS;
        cmd_eval.level  = elsp_pkg::frac_level(prog_rem[FW-1:0]);
        cmd_eval.full   = prog_full;
        cmd_eval.all_on = prog_sat == elsp_pkg::PROG_MAX;
      end
      elsp_pkg::ACT_BREATHE: begin
        // A finished half period shows the end of the ramp
        cmd_eval.level = rising_eff ? elsp_pkg::LEVEL_FULL : elsp_pkg::LEVEL_OFF;
      end
      default: begin
        cmd_eval.level = elsp_pkg::LEVEL_OFF;
      end
    endcase
  end

  // Sequencer
  always_comb begin
    fstate_nxt = fstate_r;
    case (fstate_r)
      elsp_pkg::F_IDLE: if (in_valid) fstate_nxt = elsp_pkg::F_EVAL;
      elsp_pkg::F_EVAL: fstate_nxt = (breathe && !e_full) ? elsp_pkg::F_DIV
                                                          : elsp_pkg::F_PUSH;
      elsp_pkg::F_DIV:  if (div_done) fstate_nxt = elsp_pkg::F_PUSH;
      elsp_pkg::F_PUSH: if (!q_full) fstate_nxt = elsp_pkg::F_IDLE;
      default:          fstate_nxt = elsp_pkg::F_IDLE;
    endcase
  end

  always_comb begin
    in_stall  = 1'b1;
    div_start = 1'b0;
    q_push    = 1'b0;
    case (fstate_r)
      elsp_pkg::F_IDLE: in_stall  = 1'b0;
      elsp_pkg::F_EVAL: div_start = breathe && !e_full;
      elsp_pkg::F_PUSH: q_push    = !q_full;
      default:          in_stall  = 1'b1;
    endcase
  end

  assign q_din = cmd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fstate_r       <= elsp_pkg::F_IDLE;
      spin_pos_r     <= '0;
      spin_last_r    <= '0;
      spin_pat_r     <= '0;
      pulse_start_r  <= '0;
      pulse_rising_r <= 1'b1;
      pulse_speed_r  <= '0;
    end else begin
      fstate_r <= fstate_nxt;
      if (cfg.home) begin
        spin_pos_r <= cfg.home_mirrored ? SW'(SEGMENTS - 1) : '0;
      end else if (fstate_r == elsp_pkg::F_EVAL) begin
        if (elsp_pkg::action_t'(action_r) == elsp_pkg::ACT_SPIN && spin_step) begin
          spin_last_r <= time_r;
          spin_pat_r  <= spin_new_pat;
          spin_pos_r  <= spin_pos_adv;
        end
      end
      if (fstate_r == elsp_pkg::F_EVAL && breathe) begin
        pulse_speed_r <= speed_r;
        if (e_full) begin
          pulse_start_r  <= time_r;
          pulse_rising_r <= !rising_eff;
        end else begin
          pulse_start_r  <= start_eff;
          pulse_rising_r <= rising_eff;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fstate_r == elsp_pkg::F_IDLE && in_valid) begin
      time_r   <= in_time_ms;
      action_r <= in_action;
      bright_r <= in_brightness;
      prog_r   <= in_progress;
      speed_r  <= in_pulse_speed;
    end
    if (fstate_r == elsp_pkg::F_EVAL) begin
      cmd_r <= cmd_eval;
    end else if (fstate_r == elsp_pkg::F_DIV && div_done) begin
      cmd_r.level <= pulse_rising_r ? div_quot : elsp_pkg::LEVEL_FULL - div_quot;
    end
  end

endmodule

@@ rtl/elsp_back.sv @@
module elsp_back #(
  parameter int SEGMENTS = elsp_pkg::SEGMENTS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          mirrored,
  input  elsp_pkg::cmd_t                q_dout,
  input  logic                          q_empty,
  output logic                          q_pop,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [elsp_pkg::SEG_W-1:0]    out_segment,
  output logic [elsp_pkg::LEVEL_W-1:0]  out_level,
  output logic                          out_last
);

  localparam int SW = elsp_pkg::SEG_W;

  logic           busy_r;
  logic [SW-1:0]  seg_r;
  elsp_pkg::cmd_t cmd_r;
  logic           seg_last;
  logic           load;
  logic [SW-1:0]  bar_pos;

  assign seg_last = seg_r == SW'(SEGMENTS - 1);
  assign load     = !q_empty && (!busy_r || (!out_stall && seg_last));
  assign q_pop    = load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      seg_r  <= '0;
    end else if (load) begin
      busy_r <= 1'b1;
      seg_r  <= '0;
    end else if (busy_r && !out_stall) begin
      if (seg_last) busy_r <= 1'b0;
      else          seg_r  <= seg_r + SW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load) cmd_r <= q_dout;
  end

  // Bar position counts from the last segment when mirrored
  assign bar_pos = mirrored ? SW'(SEGMENTS - 1) - seg_r : seg_r;

  always_comb begin
    case (cmd_r.kind)
      elsp_pkg::CMD_UNIFORM:  out_level = cmd_r.level;
      elsp_pkg::CMD_PATTERN:  out_level = cmd_r.pattern[seg_r] ? elsp_pkg::LEVEL_FULL
                                                               : elsp_pkg::LEVEL_OFF;
      elsp_pkg::CMD_PROGRESS: begin
        if (cmd_r.all_on || bar_pos < cmd_r.full) out_level = elsp_pkg::LEVEL_FULL;
        else if (bar_pos == cmd_r.full)           out_level = cmd_r.level;
        else                                      out_level = elsp_pkg::LEVEL_OFF;
      end
      default: out_level = elsp_pkg::LEVEL_OFF;
    endcase
  end

  assign out_valid   = busy_r;
  assign out_segment = seg_r;
  assign out_last    = seg_last;

endmodule

@@ rtl/elsp_checker.sv @@
module elsp_checker #(
  parameter int SEGMENTS = elsp_pkg::SEGMENTS_DEF
) (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [elsp_pkg::SEG_W-1:0]    out_segment,
  input logic [elsp_pkg::LEVEL_W-1:0]  out_level,
  input logic                          out_last
);

  localparam int SW = elsp_pkg::SEG_W;

  a_last_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |-> out_segment == SW'(SEGMENTS - 1))
    else $error("last mark off the final segment");

  a_seg_advance: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_last |=>
      out_valid && out_segment == $past(out_segment) + SW'(1))
    else $error("segment sequence broken inside a tick");

  a_seg_restart: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && out_last |=> !out_valid || out_segment == '0)
    else $error("new tick does not start at segment zero");

  a_tick_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("front took a tick while still classifying");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_segment) && $stable(out_level))
    else $error("stalled output changed");

endmodule

bind ear_led_segment_pattern_generator elsp_checker #(.SEGMENTS(SEGMENTS)) u_chk (.*);
